// ===== hw/rtl/bkm_pkg.sv =====
// Shared types and constants for the block key matrix multiplier.
`timescale 1ns / 1ps

package bkm_pkg;

    localparam int ROWS_MAX = 8;
    localparam int WORD_W   = 32;
    localparam int IDX_W    = 3;
    localparam int SIZE_W   = 4;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

// ===== hw/rtl/bkm_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulator.
`timescale 1ns / 1ps

module bkm_mac
    import bkm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_ctl          i_ctl,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic              o_done,
    output logic [WORD_W-1:0] o_acc
);

    t_mac_ctl          r_p_ctl;
    logic [WORD_W-1:0] r_prod;
    logic [WORD_W-1:0] r_acc;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
            r_done  <= 1'b0;
        end else begin
            r_p_ctl <= i_ctl;
            r_done  <= r_p_ctl.vld & r_p_ctl.last;
        end
    end

    // product keeps the low word only (mod 2^32)
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_p_ctl.vld) begin
            r_acc <= r_p_ctl.first ? r_prod : r_acc + r_prod;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ===== hw/rtl/block_key_matrix_multiply.sv =====
// Top level: key store, column buffer and the row/term sequencer.
// Key write or a data word that leaves its segment open: ready again next cycle.
// A data word that completes a segment starts a pass over eff rows of the key; per
// row, ST_ISSUE feeds the single multiply-accumulate unit (one key word per cycle from
// the key store's one read port), ST_DRAIN waits for the accumulator and ST_OUT holds
// the row result until taken. Ready again the cycle after the last result is taken.
// Reset (i_rst_n low, synchronous): segment count cleared, key_size set to 8; key words
// and buffered data are undefined until written.
`timescale 1ns / 1ps

module block_key_matrix_multiply
    import bkm_pkg::*;
#(
    parameter int MAX_KEY = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [39:0]       i_s_tdata,   // key_row[2:0], key_col[5:3], value[37:6], zeros
    input  logic              i_s_tuser,   // op
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [39:0]       o_m_tdata,   // out_row[2:0], out_value[34:3], zeros
    output logic              o_m_tlast
);

    localparam int LIM      = (MAX_KEY < ROWS_MAX) ? MAX_KEY : ROWS_MAX;
    localparam int KS_DEPTH = MAX_KEY * MAX_KEY;
    localparam int KS_AW    = (KS_DEPTH > 1) ? $clog2(KS_DEPTH) : 1;

    t_state            r_state;
    t_state            n_state;
    logic [SIZE_W-1:0] r_key_size;
    logic [IDX_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_k;
    logic [WORD_W-1:0] r_buf [ROWS_MAX];
    logic [WORD_W-1:0] r_mem [KS_DEPTH];
    logic [WORD_W-1:0] r_key_rd;
    logic [WORD_W-1:0] r_s1_buf;
    t_mac_ctl          r_s1;

    logic              s_op;
    logic [IDX_W-1:0]  s_row;
    logic [IDX_W-1:0]  s_col;
    logic [WORD_W-1:0] s_value;
    logic              accept;
    logic              data_acc;
    logic              seg_done;
    logic [SIZE_W-1:0] eff;
    logic [IDX_W-1:0]  size_m1;
    logic              ks_we;
    logic [KS_AW-1:0]  ks_waddr;
    logic              rd_en;
    logic [KS_AW-1:0]  ks_raddr;
    logic              mac_done;
    logic [WORD_W-1:0] mac_acc;

    assign s_op    = i_s_tuser;
    assign s_row   = i_s_tdata[2:0];
    assign s_col   = i_s_tdata[5:3];
    assign s_value = i_s_tdata[37:6];

    // effective size, clamped to 1..LIM
    always_comb begin
        if (r_key_size == '0) begin
            eff = SIZE_W'(1);
        end else if (int'(r_key_size) > LIM) begin
            eff = SIZE_W'(LIM);
        end else begin
            eff = r_key_size;
        end
    end
    assign size_m1 = IDX_W'(eff - SIZE_W'(1));

    assign accept   = i_s_tvalid & o_s_tready;
    assign data_acc = accept & (s_op == OP_DATA);
    assign seg_done = ({1'b0, r_count} + SIZE_W'(1)) >= eff;

    assign ks_we    = accept & (s_op == OP_KEY) & (int'(s_row) < MAX_KEY)
                    & (int'(s_col) < MAX_KEY);
    assign ks_waddr = KS_AW'(int'(s_row) * MAX_KEY + int'(s_col));
    assign rd_en    = (r_state == ST_ISSUE);
    assign ks_raddr = KS_AW'(int'(r_row) * MAX_KEY + int'(r_k));

    always_ff @(posedge i_clk) begin
        if (ks_we) begin
            r_mem[ks_waddr] <= s_value;
        end
        if (rd_en) begin
            r_key_rd <= r_mem[ks_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_acc) begin
            r_buf[r_count] <= s_value;
        end
        r_s1_buf <= r_buf[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_key_size <= SIZE_W'(8);
            r_count    <= '0;
            r_row      <= '0;
            r_k        <= '0;
            r_s1       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_key_size <= i_cfg_wr_data;
            end
            if (data_acc) begin
                r_count <= seg_done ? '0 : r_count + IDX_W'(1);
                r_row   <= '0;
                r_k     <= '0;
            end
            if (r_state == ST_ISSUE) begin
                r_k <= r_k + IDX_W'(1);
            end
            if ((r_state == ST_OUT) && i_m_tready) begin
                r_row <= r_row + IDX_W'(1);
                r_k   <= '0;
            end
            r_s1.vld   <= rd_en;
            r_s1.first <= (r_k == '0);
            r_s1.last  <= (r_k == size_m1);
        end
    end

    bkm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s1),
        .i_a     (r_key_rd),
        .i_b     (r_s1_buf),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (data_acc && seg_done) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_k == size_m1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_m_tready) begin
                    n_state = (r_row == size_m1) ? ST_IDLE : ST_ISSUE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // accumulator holds its row result until the next row's first product reaches it
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            ST_IDLE:  o_s_tready = 1'b1;
            ST_OUT:   o_m_tvalid = 1'b1;
            default: begin
                o_s_tready = 1'b0;
                o_m_tvalid = 1'b0;
            end
        endcase
    end

    assign o_m_tdata = {5'b0, mac_acc, r_row};
    assign o_m_tlast = (r_row == size_m1);

endmodule

// ===== hw/rtl/bkm_chk.sv =====
// Port-level checker for the block key matrix multiplier, bound to the top level.
`timescale 1ns / 1ps

module bkm_chk
    import bkm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_wr_en,
    input logic [SIZE_W-1:0] i_cfg_wr_data,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [39:0]       i_s_tdata,
    input logic              i_s_tuser,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [39:0]       o_m_tdata,
    input logic              o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_no_req_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while a result is pending");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tlast |=> o_s_tready && !o_m_tvalid)
        else $error("not ready after final result of a column");

    a_gap_between_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> !o_m_tvalid && !o_s_tready)
        else $error("next row result or request too early");

endmodule

bind block_key_matrix_multiply bkm_chk u_bkm_chk (.*);
